@@ design/lcr_pkg.sv @@
// shared types and constants for the line clipper
package lcr_pkg;

   localparam int COORD_W = 16;
   localparam int MAX_PASSES = 8;

   localparam logic [3:0] CODE_LEFT  = 4'h1;
   localparam logic [3:0] CODE_RIGHT = 4'h2;
   localparam logic [3:0] CODE_BELOW = 4'h4;
   localparam logic [3:0] CODE_ABOVE = 4'h8;

   localparam logic [2:0] CSR_CLIP_LEFT   = 3'd0;
   localparam logic [2:0] CSR_CLIP_RIGHT  = 3'd1;
   localparam logic [2:0] CSR_CLIP_TOP    = 3'd2;
   localparam logic [2:0] CSR_CLIP_BOTTOM = 3'd3;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [COORD_W:0]   diff_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      logic      visible;
      coord_type clipped_start_x;
      coord_type clipped_start_y;
      coord_type clipped_end_x;
      coord_type clipped_end_y;
   } rsp_type;

   // operands of a + (b * c) / d
   typedef struct packed {
      coord_type a;
      diff_type  b;
      diff_type  c;
      diff_type  d;
   } md_op_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV,
      MD_FIN
   } md_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CODE,
      ST_EVAL,
      ST_WAIT,
      ST_DONE
   } clip_state_type;

endpackage

@@ design/line_clip_to_rectangle.sv @@
// top level: cohen-sutherland segment clipper with serial intersection unit
//
// An item is one segment, taken at a clock edge where start is high and busy
// is low. busy stays high until the result has been shown. The result is on
// rsp_data for exactly one cycle with rsp_valid high; the receiver cannot
// stall it and must take it in that cycle.
// Clip rectangle registers are written through csr_we / csr_index / csr_wdata
// at any edge with csr_we high (index 0 left, 1 right, 2 top, 3 bottom); other
// indexes are ignored. Write them only while busy is low.
// A segment is decided without clipping or after endpoint moves, at most
// eight moves. Each move runs the intersection through a bit-serial
// multiplier and a restoring divider. Only one item is in flight at a time;
// the next can be taken in the cycle after the result. Reset (synchronous,
// active high) returns to idle and sets the rectangle to left 0, right 1023,
// top 0, bottom 767.
module line_clip_to_rectangle (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lcr_pkg::req_type req_data,
   output logic             rsp_valid,
   output lcr_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  lcr_pkg::coord_type csr_wdata
);
   import lcr_pkg::*;

   clip_state_type state_ff, state_in;
   coord_type      left_ff, right_ff, top_ff, bottom_ff;
   coord_type      x1_ff, y1_ff, x2_ff, y2_ff;
   coord_type      x1_in, y1_in, x2_in, y2_in;
   logic [3:0]     c1_ff, c2_ff, c1_in, c2_in;
   logic [3:0]     pass_ff, pass_in;
   logic           vis_ff, vis_in;
   logic           first_ff, first_in;
   logic           xedge_ff, xedge_in;
   coord_type      edge_ff, edge_in;
   md_op_type      op_ff, op_in;
   logic           go;
   logic           md_done;
   coord_type      md_res;
   logic [3:0]     code;

   function automatic logic [3:0] outcode(input coord_type x, input coord_type y,
                                          input coord_type l, input coord_type r,
                                          input coord_type t, input coord_type b);
      logic [3:0] c;
      c = '0;
      if (x < l) c |= CODE_LEFT;
      else if (x > r) c |= CODE_RIGHT;
      if (y > b) c |= CODE_BELOW;
      else if (y < t) c |= CODE_ABOVE;
      outcode = c;
   endfunction

   function automatic diff_type diff(input coord_type p, input coord_type q);
      diff = {p[COORD_W-1], p} - {q[COORD_W-1], q};
   endfunction

   always_comb begin
      state_in = state_ff;
      x1_in = x1_ff; y1_in = y1_ff; x2_in = x2_ff; y2_in = y2_ff;
      c1_in = c1_ff; c2_in = c2_ff;
      pass_in  = pass_ff;
      vis_in   = vis_ff;
      first_in = first_ff;
      xedge_in = xedge_ff;
      edge_in  = edge_ff;
      op_in    = op_ff;
      go       = 1'b0;
      code     = (c1_ff != '0) ? c1_ff : c2_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               x1_in = req_data.start_x;
               y1_in = req_data.start_y;
               x2_in = req_data.end_x;
               y2_in = req_data.end_y;
               pass_in  = '0;
               state_in = ST_CODE;
            end
         end
         ST_CODE: begin
            c1_in = outcode(x1_ff, y1_ff, left_ff, right_ff, top_ff, bottom_ff);
            c2_in = outcode(x2_ff, y2_ff, left_ff, right_ff, top_ff, bottom_ff);
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if ((c1_ff | c2_ff) == '0) begin
               vis_in   = 1'b1;
               state_in = ST_DONE;
            end else if ((c1_ff & c2_ff) != '0 || pass_ff == 4'(MAX_PASSES)) begin
               vis_in   = 1'b0;
               state_in = ST_DONE;
            end else begin
               pass_in  = pass_ff + 1'b1;
               first_in = (c1_ff != '0);
               if ((code & CODE_LEFT) != '0) begin
                  edge_in = left_ff;  xedge_in = 1'b1;
               end else if ((code & CODE_RIGHT) != '0) begin
                  edge_in = right_ff; xedge_in = 1'b1;
               end else if ((code & CODE_BELOW) != '0) begin
                  edge_in = bottom_ff; xedge_in = 1'b0;
               end else begin
                  edge_in = top_ff;   xedge_in = 1'b0;
               end
               if (xedge_in) begin
                  op_in.a = y1_ff;
                  op_in.b = diff(y2_ff, y1_ff);
                  op_in.c = diff(edge_in, x1_ff);
                  op_in.d = diff(x2_ff, x1_ff);
               end else begin
                  op_in.a = x1_ff;
                  op_in.b = diff(x2_ff, x1_ff);
                  op_in.c = diff(edge_in, y1_ff);
                  op_in.d = diff(y2_ff, y1_ff);
               end
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            // operands registered last cycle; the unit ignores go while running
            go = 1'b1;
            if (md_done) begin
               go = 1'b0;
               if (first_ff) begin
                  x1_in = xedge_ff ? edge_ff : md_res;
                  y1_in = xedge_ff ? md_res : edge_ff;
               end else begin
                  x2_in = xedge_ff ? edge_ff : md_res;
                  y2_in = xedge_ff ? md_res : edge_ff;
               end
               state_in = ST_CODE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         left_ff   <= '0;
         right_ff  <= COORD_W'(1023);
         top_ff    <= '0;
         bottom_ff <= COORD_W'(767);
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_CLIP_LEFT:   left_ff   <= csr_wdata;
               CSR_CLIP_RIGHT:  right_ff  <= csr_wdata;
               CSR_CLIP_TOP:    top_ff    <= csr_wdata;
               CSR_CLIP_BOTTOM: bottom_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      x1_ff <= x1_in; y1_ff <= y1_in; x2_ff <= x2_in; y2_ff <= y2_in;
      c1_ff <= c1_in; c2_ff <= c2_in;
      pass_ff  <= pass_in;
      vis_ff   <= vis_in;
      first_ff <= first_in;
      xedge_ff <= xedge_in;
      edge_ff  <= edge_in;
      op_ff    <= op_in;
   end

   lcr_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .go     (go),
      .op     (op_ff),
      .done   (md_done),
      .result (md_res)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_data  = '{visible: vis_ff,
                        clipped_start_x: x1_ff, clipped_start_y: y1_ff,
                        clipped_end_x: x2_ff, clipped_end_y: y2_ff};

endmodule

@@ design/lcr_muldiv.sv @@
// bit-serial multiply then restoring divide: a + (b * c) / d, truncated toward zero; a alone when d is zero
module lcr_muldiv (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  lcr_pkg::md_op_type op,
   output logic              done,
   output lcr_pkg::coord_type result
);
   import lcr_pkg::*;

   localparam int MAG_W  = COORD_W + 1;
   localparam int PROD_W = 2 * MAG_W;
   localparam int CNT_W  = $clog2(PROD_W);

   md_state_type      state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [MAG_W:0]    rem_ff, rem_in;
   logic [MAG_W-1:0]  mb_ff, mb_in;
   logic [MAG_W-1:0]  md_ff, md_in;
   logic              neg_ff, neg_in;
   logic              zero_ff, zero_in;
   coord_type         a_ff, a_in;
   coord_type         res_ff, res_in;
   logic              done_ff, done_in;

   logic [MAG_W:0]    sum;
   logic [MAG_W:0]    trial;
   logic [MAG_W-1:0]  mc;
   coord_type         q;

   function automatic logic [MAG_W-1:0] magnitude(input diff_type v);
      magnitude = v[COORD_W] ? MAG_W'(-v) : MAG_W'(v);
   endfunction

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      mb_in    = mb_ff;
      md_in    = md_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      a_in     = a_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      mc       = magnitude(op.c);
      sum      = {1'b0, prod_ff[PROD_W-1:MAG_W]} + {1'b0, mb_ff};
      trial    = {rem_ff[MAG_W-1:0], prod_ff[PROD_W-1]};
      q        = prod_ff[COORD_W-1:0];
      unique case (state_ff)
         MD_IDLE: begin
            if (go) begin
               mb_in   = magnitude(op.b);
               md_in   = magnitude(op.d);
               neg_in  = op.b[COORD_W] ^ op.c[COORD_W] ^ op.d[COORD_W];
               zero_in = (op.d == '0);
               a_in    = op.a;
               prod_in = {{MAG_W{1'b0}}, mc};
               rem_in  = '0;
               cnt_in  = '0;
               state_in = (op.d == '0) ? MD_FIN : MD_MUL;
            end
         end
         MD_MUL: begin
            // shift-add, one multiplier bit per cycle
            if (prod_ff[0]) begin
               prod_in = {sum, prod_ff[MAG_W-1:1]};
            end else begin
               prod_in = {1'b0, prod_ff[PROD_W-1:1]};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MAG_W - 1)) begin
               cnt_in   = '0;
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            // quotient bits shift in where dividend bits shift out
            if (trial >= {1'b0, md_ff}) begin
               rem_in  = trial - {1'b0, md_ff};
               prod_in = {prod_ff[PROD_W-2:0], 1'b1};
            end else begin
               rem_in  = trial;
               prod_in = {prod_ff[PROD_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(PROD_W - 1)) begin
               state_in = MD_FIN;
            end
         end
         MD_FIN: begin
            if (zero_ff) begin
               res_in = a_ff;
            end else begin
               res_in = neg_ff ? a_ff - q : a_ff + q;
            end
            done_in  = 1'b1;
            state_in = MD_IDLE;
         end
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      mb_ff   <= mb_in;
      md_ff   <= md_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      a_ff    <= a_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule
